FILE: hw/rtl/pkht_pkg.sv
package pkht_pkg;

   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 32;
   localparam int TOTAL_W   = 7;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_LOOKUP = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   typedef logic [TOTAL_W-1:0] total_type;

   typedef struct packed {
      command_type               command;
      logic signed [KEY_W-1:0]   pos_x;
      logic signed [KEY_W-1:0]   pos_y;
      logic [PAYLOAD_W-1:0]      payload_in;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [PAYLOAD_W-1:0]      payload_out;
      total_type                 entry_total;
   } rsp_type;

   // one table slot as held in memory
   typedef struct packed {
      logic                      valid;
      logic [KEY_W-1:0]          key_x;
      logic [KEY_W-1:0]          key_y;
      logic [PAYLOAD_W-1:0]      payload;
   } slot_type;

endpackage

FILE: hw/rtl/position_keyed_hash_table_unit.sv
// Flow: an accepted req is hashed to a start slot, then slots are read in order from there
//   until a hit or until all SLOTS slots are checked, and the result word is registered.
// A full-table insert or an unused command skips hashing and probing and goes to the result.
// One word at a time: req_stall stays high from acceptance until the result word is loaded;
//   one slot read per cycle from a single RAM port while probing.
// Reset: synchronous; then a clearing pass over every slot with req_stall held high.
module position_keyed_hash_table_unit #(
   parameter int SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pkht_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pkht_pkg::rsp_type rsp_word
);

   localparam int IdxW  = $clog2(SLOTS);
   localparam int CntW  = $clog2(SLOTS + 1);
   localparam int SlotW = $bits(pkht_pkg::slot_type);
   localparam logic [IdxW-1:0] LastIdx  = IdxW'(SLOTS - 1);
   localparam logic [CntW-1:0] SlotsCnt = CntW'(SLOTS);
   localparam logic [CntW-1:0] LastCnt  = CntW'(SLOTS - 1);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_HASH  = 5'b00100,
      S_PROBE = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   pkht_pkg::req_type       req_ff, req_in;
   logic [IdxW-1:0]         addr_ff, addr_in;
   logic [CntW-1:0]         issued_ff, issued_in;
   logic                    chk_valid_ff, chk_valid_in;
   logic [IdxW-1:0]         chk_slot_ff, chk_slot_in;
   logic [CntW-1:0]         checked_ff, checked_in;
   logic [CntW-1:0]         count_ff, count_in;
   pkht_pkg::status_type    res_status_ff, res_status_in;
   logic [pkht_pkg::PAYLOAD_W-1:0] res_payload_ff, res_payload_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pkht_pkg::rsp_type       rsp_ff, rsp_in;

   logic                    hash_start;
   logic                    hash_done;
   logic [IdxW-1:0]         hash_slot;
   logic [pkht_pkg::KEY_W-1:0] hash_key;

   logic                    wr_en;
   logic [IdxW-1:0]         wr_addr;
   pkht_pkg::slot_type      wr_slot;
   logic                    rd_en;
   logic [SlotW-1:0]        rd_bits;
   pkht_pkg::slot_type      rd_slot;
   logic                    key_match;
   logic                    probe_hit;
   logic [IdxW-1:0]         addr_next;

   // ---------------------------------------------------------------
   // Start slot: key x XOR y, reduced modulo SLOTS by the pkht_start_slot unit
   // ---------------------------------------------------------------
   assign hash_key = req_word.pos_x ^ req_word.pos_y;

   pkht_start_slot #(
      .SLOTS (SLOTS)
   ) u_start_slot (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (hash_key),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   // ---------------------------------------------------------------
   // Slot store: valid bit, key and payload in one word per slot
   // ---------------------------------------------------------------
   pkht_ram #(
      .WIDTH (SlotW),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_bits)
   );

   assign rd_slot   = pkht_pkg::slot_type'(rd_bits);
   assign key_match = rd_slot.valid
                      && (rd_slot.key_x == req_ff.pos_x)
                      && (rd_slot.key_y == req_ff.pos_y);
   // insert looks for a free slot, remove and lookup for a live matching key
   assign probe_hit = (req_ff.command == pkht_pkg::CMD_INSERT) ? !rd_slot.valid : key_match;
   assign addr_next = (addr_ff == LastIdx) ? '0 : IdxW'(addr_ff + 1'b1);

   assign req_stall = (state_ff != S_IDLE);

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      addr_in        = addr_ff;
      issued_in      = issued_ff;
      chk_valid_in   = 1'b0;
      chk_slot_in    = chk_slot_ff;
      checked_in     = checked_ff;
      count_in       = count_ff;
      res_status_in  = res_status_ff;
      res_payload_in = res_payload_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      hash_start     = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = chk_slot_ff;
      wr_slot        = '{valid:   1'b1,
                         key_x:   req_ff.pos_x,
                         key_y:   req_ff.pos_y,
                         payload: req_ff.payload_in};
      rd_en          = 1'b0;

      // drop the result word once taken
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            // empty one slot per cycle
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_slot = '0;
            addr_in = addr_next;
            if (addr_ff == LastIdx) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in         = req_word;
               res_status_in  = pkht_pkg::ST_OK;
               res_payload_in = '0;
               case (req_word.command) inside
                  pkht_pkg::CMD_INSERT: begin
                     if (count_ff == SlotsCnt) begin
                        res_status_in = pkht_pkg::ST_FULL;
                        state_in      = S_RESP;
                     end else begin
                        hash_start = 1'b1;
                        state_in   = S_HASH;
                     end
                  end
                  pkht_pkg::CMD_REMOVE, pkht_pkg::CMD_LOOKUP: begin
                     hash_start = 1'b1;
                     state_in   = S_HASH;
                  end
                  default: begin
                     // unused command: answer ok, leave the table alone
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_HASH: begin
            if (hash_done) begin
               addr_in    = hash_slot;
               issued_in  = '0;
               checked_in = '0;
               state_in   = S_PROBE;
            end
         end
         S_PROBE: begin
            // issue one read per cycle, check the word read last cycle
            if (issued_ff != SlotsCnt) begin
               rd_en        = 1'b1;
               chk_valid_in = 1'b1;
               chk_slot_in  = addr_ff;
               addr_in      = addr_next;
               issued_in    = CntW'(issued_ff + 1'b1);
            end
            if (chk_valid_ff) begin
               if (probe_hit) begin
                  state_in = S_RESP;
                  case (req_ff.command)
                     pkht_pkg::CMD_INSERT: begin
                        wr_en    = 1'b1;
                        count_in = CntW'(count_ff + 1'b1);
                     end
                     pkht_pkg::CMD_REMOVE: begin
                        wr_en         = 1'b1;
                        wr_slot.valid = 1'b0;
                        if (count_ff != '0) begin
                           count_in = CntW'(count_ff - 1'b1);
                        end
                     end
                     default: begin
                        res_payload_in = rd_slot.payload;
                     end
                  endcase
               end else if (checked_ff == LastCnt) begin
                  state_in      = S_RESP;
                  res_status_in = (req_ff.command == pkht_pkg::CMD_INSERT)
                                  ? pkht_pkg::ST_FULL : pkht_pkg::ST_MISSING;
               end else begin
                  checked_in = CntW'(checked_ff + 1'b1);
               end
            end
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status:      res_status_ff,
                                payload_out: res_payload_ff,
                                entry_total: pkht_pkg::total_type'(count_ff)};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         issued_ff    <= '0;
         chk_valid_ff <= 1'b0;
         checked_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         issued_ff    <= issued_in;
         chk_valid_ff <= chk_valid_in;
         checked_ff   <= checked_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff         <= req_in;
      chk_slot_ff    <= chk_slot_in;
      res_status_ff  <= res_status_in;
      res_payload_ff <= res_payload_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SlotsCnt)
      else $error("entry count above table size");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_PROBE))
      else $error("slot write outside clear or probe");

   a_count_source: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(state_ff == S_PROBE))
      else $error("entry count changed outside a probe hit");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("result word raised outside response state");

endmodule

FILE: hw/rtl/pkht_ram.sv
module pkht_ram #(
   parameter int WIDTH = 97,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/pkht_start_slot.sv
module pkht_start_slot #(
   parameter int SLOTS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pkht_pkg::KEY_W-1:0]  key,
   output logic                        done,
   output logic [$clog2(SLOTS)-1:0]    slot
);

   localparam int IdxW = $clog2(SLOTS);
   localparam int KeyW = pkht_pkg::KEY_W;
   localparam bit IsPow2 = (SLOTS & (SLOTS - 1)) == 0;

   generate
      if (IsPow2) begin : g_mask
         logic            done_ff;
         logic [IdxW-1:0] slot_ff;

         // key modulo a power of two: take the low bits
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               slot_ff <= key[IdxW-1:0];
            end
         end

         assign done = done_ff;
         assign slot = slot_ff;
      end else begin : g_fold
         localparam int ByteW    = 8;
         localparam int Bytes    = KeyW / ByteW;
         localparam int ByteCntW = $clog2(Bytes);
         localparam int StepW    = IdxW + ByteW;
         localparam int Shift    = StepW + IdxW;
         localparam int RecipW   = StepW + 1;
         localparam int ProdW    = StepW + RecipW;
         localparam logic [63:0] RecipWide =
            ((64'd1 << Shift) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
         localparam logic [RecipW-1:0]   Recip     = RecipW'(RecipWide);
         localparam logic [StepW-1:0]    SlotsStep = StepW'(SLOTS);
         localparam logic [ByteCntW-1:0] LastByte  = ByteCntW'(Bytes - 1);

         logic                busy_ff, busy_in;
         logic                done_ff, done_in;
         logic                phase_ff, phase_in;
         logic [KeyW-1:0]     bits_ff, bits_in;
         logic [IdxW-1:0]     rem_ff, rem_in;
         logic [ByteCntW-1:0] byte_cnt_ff, byte_cnt_in;
         logic [StepW-1:0]    step_ff, step_in;
         logic [ProdW-1:0]    prod_ff, prod_in;
         logic [ByteW-1:0]    quot;
         logic [StepW-1:0]    back;

         // fold in one key byte at a time: rem = (rem * 256 + byte) mod SLOTS,
         // the step quotient taken by an exact reciprocal multiplication
         always_comb begin
            busy_in     = busy_ff;
            done_in     = 1'b0;
            phase_in    = phase_ff;
            bits_in     = bits_ff;
            rem_in      = rem_ff;
            byte_cnt_in = byte_cnt_ff;
            step_in     = step_ff;
            prod_in     = prod_ff;
            quot        = prod_ff[Shift +: ByteW];
            back        = StepW'(quot) * SlotsStep;
            if (start) begin
               busy_in     = 1'b1;
               phase_in    = 1'b0;
               bits_in     = key;
               rem_in      = '0;
               byte_cnt_in = '0;
            end else if (busy_ff) begin
               if (!phase_ff) begin
                  step_in  = {rem_ff, bits_ff[KeyW-1 -: ByteW]};
                  prod_in  = ProdW'(step_in) * ProdW'(Recip);
                  phase_in = 1'b1;
               end else begin
                  rem_in      = IdxW'(step_ff - back);
                  bits_in     = {bits_ff[KeyW-ByteW-1:0], {ByteW{1'b0}}};
                  byte_cnt_in = ByteCntW'(byte_cnt_ff + 1'b1);
                  phase_in    = 1'b0;
                  if (byte_cnt_ff == LastByte) begin
                     busy_in = 1'b0;
                     done_in = 1'b1;
                  end
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff  <= 1'b0;
               done_ff  <= 1'b0;
               phase_ff <= 1'b0;
            end else begin
               busy_ff  <= busy_in;
               done_ff  <= done_in;
               phase_ff <= phase_in;
            end
            bits_ff     <= bits_in;
            rem_ff      <= rem_in;
            byte_cnt_ff <= byte_cnt_in;
            step_ff     <= step_in;
            prod_ff     <= prod_in;
         end

         assign done = done_ff;
         assign slot = rem_ff;
      end
   endgenerate

endmodule
